FILE: rtl/core/afd_pkg.sv
`default_nettype none
package afd_pkg;

    localparam int BUFFER_DEPTH = 128;
    localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
    localparam int COUNT_W      = $clog2(BUFFER_DEPTH + 1);

    localparam logic [7:0] HEADER_BYTE = 8'hBB;
    localparam logic [7:0] TAIL_FIRST  = 8'hFF;
    localparam logic [7:0] TAIL_SECOND = 8'hEE;
    localparam logic [7:0] CRC_POLY    = 8'h07;

    localparam logic [7:0] CMD_FEEDBACK = 8'h01;
    localparam logic [7:0] CMD_DIAG     = 8'h08;
    localparam logic [7:0] CMD_DONE     = 8'hCC;

    // frame lengths in bytes, header to crc
    localparam logic [6:0] LEN_FEEDBACK = 7'd46;
    localparam logic [6:0] LEN_DIAG     = 7'd81;
    localparam logic [6:0] LEN_DONE     = 7'd5;

    typedef enum logic [1:0] {
        KIND_FEEDBACK = 2'd0,
        KIND_DIAG     = 2'd1,
        KIND_DONE     = 2'd2
    } t_kind;

    // one byte of crc-8, msb first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int b = 0; b < 8; b++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/afd_ram.sv
`default_nettype none
module afd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

FILE: rtl/core/arm_feedback_frame_deframer.sv
`default_nettype none
// Byte-stream deframer for the arm feedback link. Each accepted request is one
// received byte; it is appended to a circular byte buffer and the buffer is then
// searched for a frame (header 0xBB, command, payload, tail FF EE, crc-8 poly 0x07).
// A frame that checks out is sent as little-endian 32-bit payload words, one
// result request per word, with the last flag on the final word; a done frame
// gives a single zero word. The buffer lives in a single-port-read RAM, so the
// whole search runs one byte read per clock. A byte that completes nothing goes
// through accept, check, header read and command read before the next input
// slot, or only accept and check when the buffer held nothing. A complete
// candidate frame adds a crc pass that reads each frame byte. Each byte skipped
// while hunting for a header costs a check and a header read, a dropped candidate
// header costs a check, header read and command read plus its crc pass when its
// command is known, and emission takes a read per payload byte and an output step
// per word, plus any output stall. The block takes no byte while it is searching
// or emitting. A finished word waits in the output register, so the next byte is
// taken while the last word of a frame is still pending. No clearing pass after reset.
module arm_feedback_frame_deframer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_frame_kind,
    output logic [4:0]       o_word_index,
    output logic [31:0]      o_payload_word,
    output logic             o_last
);

    localparam int AW = afd_pkg::ADDR_W;
    localparam int CW = afd_pkg::COUNT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHK,
        S_HDR,
        S_CMD,
        S_CRC,
        S_EBYTE,
        S_EOUT
    } t_state;

    t_state              r_state, n_state;
    logic [AW-1:0]       r_head, n_head;       // oldest buffered byte
    logic [CW-1:0]       r_count, n_count;     // bytes in the buffer
    logic [6:0]          r_len, n_len;         // current frame length
    logic [1:0]          r_kind, n_kind;
    logic [6:0]          r_idx, n_idx;         // byte offset in crc pass / payload
    logic [7:0]          r_crc, n_crc;
    logic [7:0]          r_tail1, n_tail1;
    logic [7:0]          r_tail2, n_tail2;
    logic [1:0]          r_lane, n_lane;
    logic [4:0]          r_widx, n_widx;
    logic [31:0]         r_word, n_word;
    logic                r_out_valid, n_out_valid;
    logic [1:0]          r_okind, n_okind;
    logic [4:0]          r_oidx, n_oidx;
    logic [31:0]         r_oword, n_oword;
    logic                r_olast, n_olast;

    logic [AW-1:0]       rd_addr;
    logic [7:0]          rd_data;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic                in_acc;
    logic                out_free;
    logic [6:0]          pay_cnt;
    logic                word_last;

    // circular address: base + offset, offset below the depth
    function automatic logic [AW-1:0] wrap(input logic [AW-1:0] base, input logic [CW-1:0] off);
        logic [AW+CW-1:0] s;
        s = {{CW{1'b0}}, base} + {{AW{1'b0}}, off};
        if (s >= (AW + CW)'(afd_pkg::BUFFER_DEPTH)) begin
            s = s - (AW + CW)'(afd_pkg::BUFFER_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    afd_ram #(
        .WIDTH (8),
        .DEPTH (afd_pkg::BUFFER_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (i_rx_byte),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    assign o_in_stall     = (r_state != S_IDLE);
    assign in_acc         = i_in_valid && (r_state == S_IDLE);
    assign out_free       = !r_out_valid || !i_out_stall;
    assign pay_cnt        = r_len - 7'd5;
    assign word_last      = (r_idx == pay_cnt - 7'd1);
    assign o_out_valid    = r_out_valid;
    assign o_frame_kind   = r_okind;
    assign o_word_index   = r_oidx;
    assign o_payload_word = r_oword;
    assign o_last         = r_olast;

    // buffer full: the oldest byte goes and the new one takes its slot
    assign wr_en   = in_acc;
    assign wr_addr = (r_count == CW'(afd_pkg::BUFFER_DEPTH)) ? r_head : wrap(r_head, r_count);

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_len       = r_len;
        n_kind      = r_kind;
        n_idx       = r_idx;
        n_crc       = r_crc;
        n_tail1     = r_tail1;
        n_tail2     = r_tail2;
        n_lane      = r_lane;
        n_widx      = r_widx;
        n_word      = r_word;
        n_out_valid = r_out_valid && i_out_stall;
        n_okind     = r_okind;
        n_oidx      = r_oidx;
        n_oword     = r_oword;
        n_olast     = r_olast;
        rd_addr     = r_head;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (r_count == CW'(afd_pkg::BUFFER_DEPTH)) begin
                        n_head = wrap(r_head, CW'(1));
                    end else begin
                        n_count = r_count + CW'(1);
                    end
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                // look at the oldest byte as a header candidate
                if (r_count < CW'(2)) begin
                    n_state = S_IDLE;
                end else begin
                    rd_addr = r_head;
                    n_state = S_HDR;
                end
            end
            S_HDR: begin
                if (rd_data != afd_pkg::HEADER_BYTE) begin
                    n_head  = wrap(r_head, CW'(1));
                    n_count = r_count - CW'(1);
                    n_state = S_CHK;
                end else begin
                    rd_addr = wrap(r_head, CW'(1));
                    n_state = S_CMD;
                end
            end
            S_CMD: begin
                case (rd_data)
                    afd_pkg::CMD_FEEDBACK: begin
                        n_len  = afd_pkg::LEN_FEEDBACK;
                        n_kind = afd_pkg::KIND_FEEDBACK;
                    end
                    afd_pkg::CMD_DIAG: begin
                        n_len  = afd_pkg::LEN_DIAG;
                        n_kind = afd_pkg::KIND_DIAG;
                    end
                    afd_pkg::CMD_DONE: begin
                        n_len  = afd_pkg::LEN_DONE;
                        n_kind = afd_pkg::KIND_DONE;
                    end
                    default: begin
                        n_len  = 7'd0;
                        n_kind = afd_pkg::KIND_FEEDBACK;
                    end
                endcase
                if (n_len == 7'd0) begin
                    // unknown command: drop the header
                    n_head  = wrap(r_head, CW'(1));
                    n_count = r_count - CW'(1);
                    n_state = S_CHK;
                end else if (CW'(n_len) > r_count) begin
                    // frame not complete yet, wait for more bytes
                    n_state = S_IDLE;
                end else begin
                    n_idx   = 7'd0;
                    n_crc   = 8'h00;
                    rd_addr = r_head;
                    n_state = S_CRC;
                end
            end
            S_CRC: begin
                // rd_data is the byte at offset r_idx
                if (r_idx == r_len - 7'd1) begin
                    if (r_tail1 == afd_pkg::TAIL_FIRST && r_tail2 == afd_pkg::TAIL_SECOND
                        && r_crc == rd_data) begin
                        n_idx  = 7'd0;
                        n_lane = 2'd0;
                        n_widx = 5'd0;
                        if (r_kind == afd_pkg::KIND_DONE) begin
                            n_word  = 32'd0;
                            n_state = S_EOUT;
                        end else begin
                            rd_addr = wrap(r_head, CW'(2));
                            n_state = S_EBYTE;
                        end
                    end else begin
                        n_head  = wrap(r_head, CW'(1));
                        n_count = r_count - CW'(1);
                        n_state = S_CHK;
                    end
                end else begin
                    n_crc = afd_pkg::crc8_byte(r_crc, rd_data);
                    if (r_idx == r_len - 7'd3) begin
                        n_tail1 = rd_data;
                    end
                    if (r_idx == r_len - 7'd2) begin
                        n_tail2 = rd_data;
                    end
                    n_idx   = r_idx + 7'd1;
                    rd_addr = wrap(r_head, CW'(n_idx));
                end
            end
            S_EBYTE: begin
                // rd_data is payload byte r_idx, lane r_lane
                case (r_lane)
                    2'd0:    n_word = {24'd0, rd_data};
                    2'd1:    n_word = {r_word[31:16], rd_data, r_word[7:0]};
                    2'd2:    n_word = {r_word[31:24], rd_data, r_word[15:0]};
                    default: n_word = {rd_data, r_word[23:0]};
                endcase
                if (r_lane == 2'd3 || word_last) begin
                    n_state = S_EOUT;
                end else begin
                    n_idx   = r_idx + 7'd1;
                    n_lane  = r_lane + 2'd1;
                    rd_addr = wrap(r_head, CW'(n_idx + 7'd2));
                end
            end
            S_EOUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_okind     = r_kind;
                    n_oidx      = r_widx;
                    n_oword     = r_word;
                    n_olast     = (r_kind == afd_pkg::KIND_DONE) || word_last;
                    if (n_olast) begin
                        // frame consumed; remaining bytes wait for the next byte
                        n_head  = wrap(r_head, CW'(r_len));
                        n_count = r_count - CW'(r_len);
                        n_state = S_IDLE;
                    end else begin
                        n_widx  = r_widx + 5'd1;
                        n_idx   = r_idx + 7'd1;
                        n_lane  = 2'd0;
                        rd_addr = wrap(r_head, CW'(n_idx + 7'd2));
                        n_state = S_EBYTE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_len   <= n_len;
        r_kind  <= n_kind;
        r_idx   <= n_idx;
        r_crc   <= n_crc;
        r_tail1 <= n_tail1;
        r_tail2 <= n_tail2;
        r_lane  <= n_lane;
        r_widx  <= n_widx;
        r_word  <= n_word;
        r_okind <= n_okind;
        r_oidx  <= n_oidx;
        r_oword <= n_oword;
        r_olast <= n_olast;
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(afd_pkg::BUFFER_DEPTH))
        else $error("buffer count above depth");

    a_hdr_needs_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HDR) |-> (r_count >= CW'(2)))
        else $error("header check with fewer than two bytes");

    a_crc_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CRC) |-> (r_idx < r_len && CW'(r_len) <= r_count))
        else $error("crc pass outside buffered frame");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_oword)))
        else $error("pending word overwritten");
`endif

endmodule
`default_nettype wire
